// ===== rtl/core/pmu_pkg.sv =====
package pmu_pkg;

   localparam int TABLE_ENTRIES = 1024;
   localparam int USAGE_BITS    = 48;
   localparam int IDX_W         = $clog2(TABLE_ENTRIES);
   localparam int CNT_W         = $clog2(TABLE_ENTRIES + 1);
   localparam int TYPE_W        = 3;
   localparam int KEY_W         = 22;
   localparam int AMT_W         = 48;
   localparam int STATUS_W      = 3;
   localparam int TOTAL_W       = 32;
   localparam int OUT_W         = 48;
   localparam int SUM_W         = ((USAGE_BITS > AMT_W) ? USAGE_BITS : AMT_W) + 1;

   localparam logic [TYPE_W-1:0] OP_ALLOC = 3'd0;
   localparam logic [TYPE_W-1:0] OP_FREE  = 3'd1;
   localparam logic [TYPE_W-1:0] OP_MAP   = 3'd2;
   localparam logic [TYPE_W-1:0] OP_UNMAP = 3'd3;
   localparam logic [TYPE_W-1:0] OP_EXEC  = 3'd4;
   localparam logic [TYPE_W-1:0] OP_EXIT  = 3'd5;

   localparam logic [STATUS_W-1:0] ST_UPDATED = 3'd0;
   localparam logic [STATUS_W-1:0] ST_CREATED = 3'd1;
   localparam logic [STATUS_W-1:0] ST_FULL    = 3'd2;
   localparam logic [STATUS_W-1:0] ST_REMOVED = 3'd3;
   localparam logic [STATUS_W-1:0] ST_ABSENT  = 3'd4;

   typedef enum logic [1:0] {
      SLOT_EMPTY,
      SLOT_USED,
      SLOT_GONE
   } slot_state_type;

   typedef struct packed {
      slot_state_type          state;
      logic [KEY_W-1:0]        key;
      logic [TOTAL_W-1:0]      allocs;
      logic [TOTAL_W-1:0]      frees;
      logic [USAGE_BITS-1:0]   usage;
      logic [USAGE_BITS-1:0]   peak;
   } slot_type;

   typedef struct packed {
      logic [TYPE_W-1:0] op;
      logic [KEY_W-1:0]  key;
      logic [AMT_W-1:0]  amount;
      logic              is_remove;
      logic              is_query;
   } job_type;

   typedef enum logic [2:0] {
      BK_CLEAR,
      BK_IDLE,
      BK_READ,
      BK_CHECK,
      BK_WRITE
   } back_state_type;

   // fold the key onto the index width, then bring it into range
   function automatic logic [IDX_W-1:0] key_hash(input logic [KEY_W-1:0] key);
      logic [IDX_W-1:0] h;
      h = '0;
      for (int i = 0; i < KEY_W; i++) begin
         h[i % IDX_W] = h[i % IDX_W] ^ key[i];
      end
      if ({1'b0, h} >= (IDX_W+1)'(TABLE_ENTRIES)) begin
         h = IDX_W'({1'b0, h} - (IDX_W+1)'(TABLE_ENTRIES));
      end
      return h;
   endfunction

endpackage

// ===== rtl/core/pmu_if.sv =====
interface pmu_req_if;
   import pmu_pkg::*;
   logic              valid;
   logic              ready;
   logic [TYPE_W-1:0] req_type;
   logic [KEY_W-1:0]  proc_id;
   logic [AMT_W-1:0]  amount;
   modport source (output valid, req_type, proc_id, amount, input ready);
   modport sink   (input valid, req_type, proc_id, amount, output ready);
endinterface

interface pmu_rsp_if;
   import pmu_pkg::*;
   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   logic [TOTAL_W-1:0]  alloc_total;
   logic [TOTAL_W-1:0]  free_total;
   logic [OUT_W-1:0]    usage_now;
   logic [OUT_W-1:0]    usage_peak;
   modport source (output valid, status, alloc_total, free_total, usage_now, usage_peak,
                   input ready);
   modport sink   (input valid, status, alloc_total, free_total, usage_now, usage_peak,
                   output ready);
endinterface

// ===== rtl/core/pmu_front.sv =====
module pmu_front import pmu_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   pmu_req_if.sink    req_chan,
   output job_type    job,
   output logic       job_valid,
   input  logic       job_pop
);

   job_type    q_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] fill_ff, fill_in;
   logic       push;
   job_type    word;

   // classify the incoming word
   always_comb begin
      word.op        = req_chan.req_type;
      word.key       = req_chan.proc_id;
      word.amount    = req_chan.amount;
      word.is_remove = (req_chan.req_type == OP_EXIT);
      word.is_query  = (req_chan.req_type > OP_EXIT);
   end

   assign req_chan.ready = (fill_ff != 2'd2);
   assign push           = req_chan.valid && req_chan.ready;
   assign job_valid      = (fill_ff != 2'd0);
   assign job            = q_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ job_pop;
      fill_in   = fill_ff + {1'b0, push} - {1'b0, job_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff   <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= word;
      end
   end

endmodule

// ===== rtl/core/pmu_back.sv =====
module pmu_back import pmu_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  job_type    job,
   input  logic       job_valid,
   output logic       job_pop,
   pmu_rsp_if.source  rsp_chan
);

   slot_type         mem [TABLE_ENTRIES];
   slot_type         rd_data_ff;
   back_state_type   state_ff, state_in;
   logic [IDX_W-1:0] clr_ff;
   job_type          job_ff;
   logic [IDX_W-1:0] addr_ff;
   logic [IDX_W-1:0] probe_cnt_ff;
   logic             free_vld_ff;
   logic [IDX_W-1:0] free_addr_ff;
   logic             hit_ff;
   slot_type         rec_ff;
   logic [IDX_W-1:0] slot_ff;
   logic [CNT_W-1:0] live_ff;

   logic                rsp_valid_ff;
   logic [STATUS_W-1:0] status_ff;
   logic [TOTAL_W-1:0]  allocs_ff, frees_ff;
   logic [OUT_W-1:0]    usage_ff, peak_ff;

   logic             is_hit, is_empty, is_last;
   logic             out_free;
   logic             mem_we;
   logic [IDX_W-1:0] mem_wa;
   slot_type         mem_wd;
   logic [IDX_W-1:0] rd_addr;
   slot_type         upd;
   logic [STATUS_W-1:0] upd_status;
   logic             upd_write, upd_zero, upd_ins, upd_del;
   logic [SUM_W-1:0] sum, cur, amt;

   assign is_hit   = (rd_data_ff.state == SLOT_USED) && (rd_data_ff.key == job_ff.key);
   assign is_empty = (rd_data_ff.state == SLOT_EMPTY);
   assign is_last  = (probe_cnt_ff == IDX_W'(TABLE_ENTRIES - 1));
   assign out_free = !rsp_valid_ff || rsp_chan.ready;
   assign job_pop  = (state_ff == BK_IDLE) && job_valid;
   assign rd_addr  = addr_ff;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         BK_CLEAR: if (clr_ff == IDX_W'(TABLE_ENTRIES - 1)) state_in = BK_IDLE;
         BK_IDLE:  if (job_valid) state_in = BK_READ;
         BK_READ:  state_in = BK_CHECK;
         BK_CHECK: begin
            if (is_hit || is_empty || is_last) state_in = BK_WRITE;
            else state_in = BK_READ;
         end
         BK_WRITE: if (out_free) state_in = BK_IDLE;
         default:  state_in = BK_CLEAR;
      endcase
   end

   // new record and status for the item in hand
   always_comb begin
      upd        = rec_ff;
      upd_status = ST_UPDATED;
      upd_write  = 1'b0;
      upd_zero   = 1'b0;
      upd_ins    = 1'b0;
      upd_del    = 1'b0;
      cur        = '0;
      amt        = SUM_W'(job_ff.amount);
      sum        = '0;
      if (job_ff.is_remove) begin
         upd_zero = 1'b1;
         if (hit_ff) begin
            upd_status = ST_REMOVED;
            upd_write  = 1'b1;
            upd_del    = 1'b1;
            upd.state  = SLOT_GONE;
         end else begin
            upd_status = ST_ABSENT;
         end
      end else if (job_ff.is_query) begin
         if (!hit_ff) begin
            upd_status = ST_ABSENT;
            upd_zero   = 1'b1;
         end
      end else if (!hit_ff && (live_ff == CNT_W'(TABLE_ENTRIES))) begin
         upd_status = ST_FULL;
         upd_zero   = 1'b1;
      end else begin
         upd_write = 1'b1;
         if (!hit_ff) begin
            upd_status = ST_CREATED;
            upd_ins    = 1'b1;
            upd.allocs = '0;
            upd.frees  = '0;
            upd.usage  = '0;
            upd.peak   = '0;
         end
         upd.state = SLOT_USED;
         upd.key   = job_ff.key;
         cur       = SUM_W'(upd.usage);
         sum       = cur + amt;
         if ((job_ff.op == OP_ALLOC) && (upd.allocs != '1)) upd.allocs = upd.allocs + 1'b1;
         if ((job_ff.op == OP_FREE) && (upd.frees != '1)) upd.frees = upd.frees + 1'b1;
         if ((job_ff.op == OP_ALLOC) || (job_ff.op == OP_MAP)) begin
            if (sum > SUM_W'({USAGE_BITS{1'b1}})) upd.usage = '1;
            else upd.usage = USAGE_BITS'(sum);
            if (upd.usage > upd.peak) upd.peak = upd.usage;
         end else if ((job_ff.op == OP_FREE) || (job_ff.op == OP_UNMAP)) begin
            if (cur >= amt) upd.usage = USAGE_BITS'(cur - amt);
         end else begin
            upd.allocs = '0;
            upd.frees  = '0;
            upd.usage  = '0;
            upd.peak   = '0;
         end
      end
   end

   always_comb begin
      mem_we = 1'b0;
      mem_wa = slot_ff;
      mem_wd = upd;
      unique case (state_ff)
         BK_CLEAR: begin
            mem_we       = 1'b1;
            mem_wa       = clr_ff;
            mem_wd       = '0;
            mem_wd.state = SLOT_EMPTY;
         end
         BK_WRITE: mem_we = upd_write && out_free;
         default:  mem_we = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_wa] <= mem_wd;
      end
      rd_data_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_CLEAR;
         clr_ff       <= '0;
         live_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (state_ff == BK_CLEAR) clr_ff <= clr_ff + 1'b1;
         if ((state_ff == BK_WRITE) && out_free) rsp_valid_ff <= 1'b1;
         else if (rsp_chan.ready) rsp_valid_ff <= 1'b0;
         if ((state_ff == BK_WRITE) && out_free) begin
            if (upd_ins) live_ff <= live_ff + 1'b1;
            if (upd_del) live_ff <= live_ff - 1'b1;
         end
      end
   end

   // probe and result payload
   always_ff @(posedge clock) begin
      unique case (state_ff)
         BK_IDLE: begin
            job_ff       <= job;
            addr_ff      <= key_hash(job.key);
            probe_cnt_ff <= '0;
            free_vld_ff  <= 1'b0;
         end
         BK_CHECK: begin
            rec_ff <= rd_data_ff;
            hit_ff <= is_hit;
            // a miss lands in the first reusable slot seen along the chain
            if (!is_hit && free_vld_ff) slot_ff <= free_addr_ff;
            else slot_ff <= addr_ff;
            if (!is_hit && !is_empty && !free_vld_ff && (rd_data_ff.state != SLOT_USED)) begin
               free_vld_ff  <= 1'b1;
               free_addr_ff <= addr_ff;
            end
            if (!is_last && !is_hit && !is_empty) begin
               probe_cnt_ff <= probe_cnt_ff + 1'b1;
               if (addr_ff == IDX_W'(TABLE_ENTRIES - 1)) addr_ff <= '0;
               else addr_ff <= addr_ff + 1'b1;
            end
         end
         BK_WRITE: begin
            if (out_free) begin
               status_ff <= upd_status;
               allocs_ff <= upd_zero ? '0 : upd.allocs;
               frees_ff  <= upd_zero ? '0 : upd.frees;
               usage_ff  <= upd_zero ? '0 : OUT_W'(upd.usage);
               peak_ff   <= upd_zero ? '0 : OUT_W'(upd.peak);
            end
         end
         default: begin
         end
      endcase
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.status      = status_ff;
   assign rsp_chan.alloc_total = allocs_ff;
   assign rsp_chan.free_total  = frees_ff;
   assign rsp_chan.usage_now   = usage_ff;
   assign rsp_chan.usage_peak  = peak_ff;

endmodule

// ===== rtl/core/per_process_memory_usage_table.sv =====
// Flow: BK_IDLE takes a queued word and hashes its key; each probe step reads one
// table slot (BK_READ, BK_CHECK) along the linear probe chain; BK_WRITE updates
// the slot if needed and registers the result word before the next word is taken.
// Reset: synchronous; a clearing pass over all TABLE_ENTRIES slots marks every slot
// empty before the first word leaves the input queue.
module per_process_memory_usage_table import pmu_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   pmu_req_if.sink   req_chan,
   pmu_rsp_if.source rsp_chan
);

   // queued work between the classifying front and the table engine
   job_type job;
   logic    job_valid;
   logic    job_pop;

   // accept and classify words into a two-deep queue
   pmu_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .job       (job),
      .job_valid (job_valid),
      .job_pop   (job_pop)
   );

   // hash, probe, read-modify-write the slot and hold the result word
   pmu_back u_back (
      .clock     (clock),
      .reset     (reset),
      .job       (job),
      .job_valid (job_valid),
      .job_pop   (job_pop),
      .rsp_chan  (rsp_chan)
   );

endmodule

// ===== verif/testbench.sv =====
module testbench;
   import pmu_pkg::*;

   // Codes the package leaves unnamed: the block must treat them as plain lookups.
   localparam logic [TYPE_W-1:0] OP_SPARE_LO = 3'd6;
   localparam logic [TYPE_W-1:0] OP_SPARE_HI = 3'd7;

   localparam logic [USAGE_BITS-1:0] USAGE_TOP = {USAGE_BITS{1'b1}};
   localparam logic [AMT_W-1:0]      AMT_TOP   = {AMT_W{1'b1}};
   localparam logic [KEY_W-1:0]      KEY_TOP   = {KEY_W{1'b1}};

   // Slowest legal gap between words: clearing pass, a probe of the whole table
   // and the long receiver hold-off, taken several times over.
   localparam int STALL_LIMIT = 40000;
   localparam int HOLD_CYCLES = 400;
   localparam int TAIL_CYCLES = 2 * TABLE_ENTRIES + 20;

   typedef struct {
      logic [TOTAL_W-1:0]    allocs;
      logic [TOTAL_W-1:0]    frees;
      logic [USAGE_BITS-1:0] usage;
      logic [USAGE_BITS-1:0] peak;
   } usage_record_type;

   typedef struct {
      logic [STATUS_W-1:0] status;
      usage_record_type    rec;
   } usage_reply_type;

   logic clock;
   logic reset;

   pmu_req_if req_chan ();
   pmu_rsp_if rsp_chan ();

   per_process_memory_usage_table i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   // Shadow of the table: records by process id, and the number held.
   usage_record_type usage_table [logic [KEY_W-1:0]];
   usage_reply_type  pending_replies [$];
   int               mismatches;
   logic             calm;       // no idling on either side while set
   logic             hold_rsp;   // ask the receiver for one long hold-off
   logic             hold_done;

   always begin
      clock = 1'b1;
      #10;
      clock = 1'b0;
      #10;
   end

   // ---------------------------------------------------------------------------
   // Predictor: apply one event to the shadow table and return the reply
   // ---------------------------------------------------------------------------
   function automatic usage_reply_type apply_event(input logic [TYPE_W-1:0] op,
                                                   input logic [KEY_W-1:0] key,
                                                   input logic [AMT_W-1:0] amt);
      usage_reply_type  reply;
      usage_record_type rec;
      logic             present;
      reply.status = ST_UPDATED;
      reply.rec    = '{default: '0};
      rec          = '{default: '0};
      present      = usage_table.exists(key);
      if (present) begin
         rec = usage_table[key];
      end
      // exit drops the record; the reply never carries it
      if (op == OP_EXIT) begin
         reply.status = present ? ST_REMOVED : ST_ABSENT;
         if (present) begin
            usage_table.delete(key);
         end
         return reply;
      end
      // spare codes only look the record up
      if (op == OP_SPARE_LO || op == OP_SPARE_HI) begin
         reply.status = present ? ST_UPDATED : ST_ABSENT;
         if (present) begin
            reply.rec = rec;
         end
         return reply;
      end
      if (!present) begin
         if (usage_table.num() >= TABLE_ENTRIES) begin
            reply.status = ST_FULL;
            return reply;
         end
         reply.status = ST_CREATED;
      end
      case (op)
         OP_ALLOC, OP_MAP: begin
            if (op == OP_ALLOC && rec.allocs != {TOTAL_W{1'b1}}) begin
               rec.allocs = rec.allocs + 1'b1;
            end
            // saturate the usage, then raise the peak
            if (amt > USAGE_TOP - rec.usage) begin
               rec.usage = USAGE_TOP;
            end else begin
               rec.usage = rec.usage + amt;
            end
            if (rec.usage > rec.peak) begin
               rec.peak = rec.usage;
            end
         end
         OP_FREE, OP_UNMAP: begin
            if (op == OP_FREE && rec.frees != {TOTAL_W{1'b1}}) begin
               rec.frees = rec.frees + 1'b1;
            end
            // only subtract what the usage covers
            if (rec.usage >= amt) begin
               rec.usage = rec.usage - amt;
            end
         end
         default: begin
            rec = '{default: '0};
         end
      endcase
      usage_table[key] = rec;
      reply.rec = rec;
      return reply;
   endfunction

   // ---------------------------------------------------------------------------
   // Sender: offer one word, hold valid high across back-to-back words
   // ---------------------------------------------------------------------------
   task automatic send_event(input logic [TYPE_W-1:0] op, input logic [KEY_W-1:0] key,
                             input logic [AMT_W-1:0] amt);
      // idle for a random spell before offering
      while (!calm && $urandom_range(99) < 24) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid    <= 1'b1;
      req_chan.req_type <= op;
      req_chan.proc_id  <= key;
      req_chan.amount   <= amt;
      do begin
         @(posedge clock);
      end while (!req_chan.ready);
      pending_replies.push_back(apply_event(op, key, amt));
   endtask

   // drop valid and wait for every outstanding reply, plus the tail of the block
   task automatic drain_replies();
      req_chan.valid <= 1'b0;
      @(posedge clock);
      while (pending_replies.size() != 0) begin
         @(posedge clock);
      end
      repeat (20) @(posedge clock);
   endtask

   // ---------------------------------------------------------------------------
   // Receiver: random back-pressure, a calm stretch and one long hold-off
   // ---------------------------------------------------------------------------
   initial begin
      int held;
      held = 0;
      hold_done = 1'b0;
      rsp_chan.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_rsp && !hold_done) begin
            rsp_chan.ready <= 1'b0;
            held = held + 1;
            if (held >= HOLD_CYCLES) begin
               hold_done <= 1'b1;
            end
         end else if (calm) begin
            rsp_chan.ready <= 1'b1;
         end else begin
            rsp_chan.ready <= ($urandom_range(99) >= 24);
         end
      end
   end

   // ---------------------------------------------------------------------------
   // Checker: compare each reply word with the oldest expectation
   // ---------------------------------------------------------------------------
   task automatic report_mismatch(input string field, input logic [63:0] got,
                                  input logic [63:0] want);
      $display("reply %s: got 0x%0h, want 0x%0h at %0t", field, got, want, $realtime);
      mismatches = mismatches + 1;
   endtask

   always @(posedge clock) begin
      usage_reply_type want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (pending_replies.size() == 0) begin
            report_mismatch("unexpected word", 64'(rsp_chan.status), 64'd0);
         end else begin
            want = pending_replies.pop_front();
            if (rsp_chan.status !== want.status)
               report_mismatch("status", 64'(rsp_chan.status), 64'(want.status));
            if (rsp_chan.alloc_total !== want.rec.allocs)
               report_mismatch("alloc_total", 64'(rsp_chan.alloc_total), 64'(want.rec.allocs));
            if (rsp_chan.free_total !== want.rec.frees)
               report_mismatch("free_total", 64'(rsp_chan.free_total), 64'(want.rec.frees));
            if (rsp_chan.usage_now !== OUT_W'(want.rec.usage))
               report_mismatch("usage_now", 64'(rsp_chan.usage_now), 64'(want.rec.usage));
            if (rsp_chan.usage_peak !== OUT_W'(want.rec.peak))
               report_mismatch("usage_peak", 64'(rsp_chan.usage_peak), 64'(want.rec.peak));
         end
      end
   end

   // Watchdog: give up after a long spell with no word moving either way.
   initial begin
      int stall;
      stall = 0;
      while (stall < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready)) begin
            stall = 0;
         end else begin
            stall = stall + 1;
         end
      end
      $display("per_process_memory_usage_table: mismatch");
      $finish;
   end

   // ---------------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------------

   // Field extremes, every operation and each corner of the record update.
   task automatic test_directed();
      logic [KEY_W-1:0] k;
      k = 22'h000123;
      send_event(OP_ALLOC, k, 48'd100);          // creates the record
      send_event(OP_ALLOC, k, AMT_TOP);          // usage saturates
      send_event(OP_MAP, k, AMT_TOP);            // stays saturated
      send_event(OP_FREE, k, AMT_TOP);           // covered exactly, drops to zero
      send_event(OP_UNMAP, k, 48'd1);            // not covered, no change
      send_event(OP_MAP, k, 48'd500);
      send_event(OP_UNMAP, k, 48'd500);
      send_event(OP_FREE, k, 48'd0);
      send_event(OP_SPARE_LO, k, AMT_TOP);       // plain lookup of a present record
      send_event(OP_EXEC, k, AMT_TOP);           // zeroes the present record
      send_event(OP_SPARE_HI, k, 48'd0);
      send_event(OP_EXIT, k, 48'd0);             // removed
      send_event(OP_EXIT, k, 48'd0);             // absent
      send_event(OP_SPARE_LO, k, 48'd0);         // lookup of an absent key
      send_event(OP_EXEC, KEY_TOP, 48'd7);       // exec creates
      send_event(OP_FREE, 22'd0, AMT_TOP);       // free creates, nothing to subtract
      send_event(OP_UNMAP, 22'h2AAAAA, 48'h555555555555);
      send_event(OP_MAP, 22'h155555, 48'hAAAAAAAAAAAA);
      send_event(OP_ALLOC, KEY_TOP, 48'd1);
      send_event(OP_EXIT, KEY_TOP, 48'd0);
      send_event(OP_EXIT, 22'd0, 48'd0);
      drain_replies();
   endtask

   // Mostly events on a small pool of live processes, with some stray keys.
   task automatic test_random_traffic();
      logic [KEY_W-1:0] pool [48];
      logic [KEY_W-1:0] k;
      logic [TYPE_W-1:0] op;
      logic [AMT_W-1:0]  amt;
      int pick;
      foreach (pool[i]) pool[i] = KEY_W'($urandom);
      pool[0] = '0;
      pool[1] = KEY_TOP;
      for (int n = 0; n < 890; n++) begin
         // a stretch in the middle runs with no idling at all
         calm <= (n >= 300 && n < 450);
         k = ($urandom_range(99) < 90) ? pool[$urandom_range(47)] : KEY_W'($urandom);
         pick = $urandom_range(99);
         if (pick < 25) op = OP_ALLOC;
         else if (pick < 50) op = OP_FREE;
         else if (pick < 65) op = OP_MAP;
         else if (pick < 80) op = OP_UNMAP;
         else if (pick < 88) op = OP_EXEC;
         else if (pick < 95) op = OP_EXIT;
         else op = $urandom_range(1) ? OP_SPARE_HI : OP_SPARE_LO;
         pick = $urandom_range(99);
         if (pick < 50) amt = AMT_W'($urandom_range(4095));
         else if (pick < 60) amt = AMT_TOP;
         else if (pick < 70 && usage_table.exists(k)) amt = usage_table[k].usage;
         else amt = AMT_W'({16'($urandom), 32'($urandom)});
         send_event(op, k, amt);
      end
      calm <= 1'b0;
      drain_replies();
   endtask

   // Stall the receiver for a long spell while the sender keeps offering words.
   task automatic test_backpressure();
      hold_rsp <= 1'b1;
      for (int n = 0; n < 40; n++) begin
         send_event($urandom_range(1) ? OP_ALLOC : OP_FREE, 22'h03C0DE,
                    AMT_W'($urandom_range(1000)));
      end
      drain_replies();
      hold_rsp <= 1'b0;
   endtask

   initial begin
      mismatches        = 0;
      calm              = 1'b0;
      hold_rsp          = 1'b0;
      reset             = 1'b1;
      req_chan.valid    = 1'b0;
      req_chan.req_type = '0;
      req_chan.proc_id  = '0;
      req_chan.amount   = '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_random_traffic();
      test_backpressure();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatches == 0 && pending_replies.size() == 0) begin
         $display("per_process_memory_usage_table: match");
      end else begin
         $display("per_process_memory_usage_table: mismatch");
      end
      $finish;
   end

endmodule
